@@ design/chp_pkg.sv @@
// Shared types and constants of the chained hash slot pool.
package chp_pkg;

    // Field widths
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 34;
    localparam int TMAX_W     = 40;
    localparam int OUT_SLOT_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Hash: fold to one word, reduce HASH_DIGIT_W (4) bits per cycle
    localparam int HASH_WORD_W  = 32;
    localparam int HASH_DIGIT_W = 4;
    localparam int HASH_STEPS   = HASH_WORD_W / HASH_DIGIT_W;
    localparam int HASH_CNT_W   = $clog2(HASH_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_LIMIT  = 1'd1;

    // Configuration reset values: 1 GiB and 10 GiB
    localparam logic [LEN_W-1:0] DEFAULT_CAP_RST = 34'h0_4000_0000;
    localparam logic [LEN_W-1:0] HARD_LIMIT_RST  = 34'h2_8000_0000;

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_BAD     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_EXCEEDS   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_BKT_WAIT,
        S_WALK,
        S_RESOLVE,
        S_ALLOC,
        S_UNLINK,
        S_DONE
    } t_state;

endpackage

@@ design/chp_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module chp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/chp_hash.sv @@
// Bucket hash: folded key word reduced modulo the bucket count, a digit per cycle.
module chp_hash #(
    parameter int NUM_BUCKETS = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [chp_pkg::HASH_WORD_W-1:0]    i_word,
    output logic                               o_done,
    output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] o_bucket
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [BW:0] MODULUS = (BW + 1)'(NUM_BUCKETS);

    logic                              r_busy;
    logic                              r_done;
    logic [chp_pkg::HASH_CNT_W-1:0]    r_cnt;
    logic [chp_pkg::HASH_WORD_W-1:0]   r_word;
    logic [BW-1:0]                     r_rem;
    logic [BW-1:0]                     n_rem;
    logic [BW:0]                       step_t;

    // Shift in one digit: remainder stays below the modulus after each bit
    always_comb begin
        n_rem  = r_rem;
        step_t = '0;
        for (int i = 0; i < chp_pkg::HASH_DIGIT_W; i++) begin
            step_t = {n_rem, r_word[chp_pkg::HASH_WORD_W-1-i]};
            if (step_t >= MODULUS) begin
                step_t = step_t - MODULUS;
            end
            n_rem = step_t[BW-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= chp_pkg::HASH_CNT_W'(chp_pkg::HASH_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= r_word << chp_pkg::HASH_DIGIT_W;
            r_rem  <= n_rem;
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

@@ design/chained_hash_slot_pool.sv @@
// Chained hash slot pool: one request at a time, one result per request.
// An invalid request goes straight to the result; a valid one is hashed, its bucket head read
//   and its chain walked, then resolved, plus an allocate or unlink step for a new-slot append or a release hit.
// A new request is taken only after the previous result is loaded into the output register.
// Reset: synchronous; a clearing pass then initializes both memories, with input
//   stalled meanwhile.
module chained_hash_slot_pool #(
    parameter int NUM_SLOTS   = 32,
    parameter int NUM_BUCKETS = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [chp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [chp_pkg::LEN_W-1:0]           i_cfg_wdata,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [chp_pkg::KEY_W-1:0]           i_key,
    input  logic [chp_pkg::LEN_W-1:0]           i_append_length,
    input  logic [chp_pkg::TMAX_W-1:0]          i_type_max_size,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic                                o_found,
    output logic [chp_pkg::OUT_SLOT_W-1:0]      o_slot_index,
    output logic [chp_pkg::LEN_W-1:0]           o_byte_offset
);

    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int BW        = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CLR_DEPTH = (NUM_SLOTS > NUM_BUCKETS) ? NUM_SLOTS : NUM_BUCKETS;
    localparam int CW        = $clog2(CLR_DEPTH + 1);

    typedef struct packed {
        logic [chp_pkg::KEY_W-1:0] key;   // zero marks a free slot
        logic [SW-1:0]             next;
        logic                      nv;
        logic [chp_pkg::LEN_W-1:0] fill;
        logic [chp_pkg::LEN_W-1:0] cap;
    } t_slot_ent;

    typedef struct packed {
        logic [SW-1:0] head;
        logic          hv;
    } t_bkt_ent;

    // State
    chp_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_clr_cnt;
    logic [SW-1:0]   r_free_head, n_free_head;
    logic            r_free_valid, n_free_valid;
    logic [chp_pkg::LEN_W-1:0] r_default_cap, r_hard_limit;

    // Request and walk registers
    chp_pkg::t_req             r_type;
    logic [chp_pkg::KEY_W-1:0] r_key;
    logic [chp_pkg::LEN_W-1:0] r_len;
    logic [chp_pkg::TMAX_W-1:0] r_tmax;
    logic [BW-1:0]             r_bucket, n_bucket;
    logic [SW-1:0]             r_bhead, n_bhead;
    logic                      r_bvalid, n_bvalid;
    logic [SW-1:0]             r_cur, n_cur;
    logic [SW-1:0]             r_prev, n_prev;
    logic                      r_has_prev, n_has_prev;
    logic                      r_hit, n_hit;
    t_slot_ent                 r_prev_ent, n_prev_ent;
    t_slot_ent                 r_hit_ent, n_hit_ent;
    logic [chp_pkg::LEN_W-1:0] r_cap, n_cap;

    // Result registers
    chp_pkg::t_status          r_res_status, n_res_status;
    logic                      r_res_found, n_res_found;
    logic [SW-1:0]             r_res_slot, n_res_slot;
    logic [chp_pkg::LEN_W-1:0] r_res_off, n_res_off;

    // Output register
    logic                           r_out_valid;
    chp_pkg::t_status               r_o_status;
    logic                           r_o_found;
    logic [chp_pkg::OUT_SLOT_W-1:0] r_o_slot;
    logic [chp_pkg::LEN_W-1:0]      r_o_off;

    // Memory ports
    logic            slot_we, bkt_we;
    logic [SW-1:0]   slot_waddr, slot_raddr, bkt_wslot;
    logic [BW-1:0]   bkt_waddr, bkt_raddr;
    t_slot_ent       slot_wdata, slot_rdata;
    t_bkt_ent        bkt_wdata, bkt_rdata;

    // Misc
    logic                          in_acc, req_bad, out_free, load_out, walk_match;
    logic                          hash_done;
    logic [BW-1:0]                 hash_bucket;
    logic [chp_pkg::HASH_WORD_W-1:0] hash_word;
    logic [chp_pkg::LEN_W:0]       fill_sum;
    logic [chp_pkg::TMAX_W-1:0]    cap_pick;
    logic [CW-1:0]                 clr_next;
    logic [SW+chp_pkg::OUT_SLOT_W-1:0] slot_ext;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign req_bad    = (chp_pkg::t_req'(i_req_type) == chp_pkg::REQ_BAD) || (i_key == '0)
                        || ((chp_pkg::t_req'(i_req_type) == chp_pkg::REQ_APPEND)
                            && (i_append_length == '0));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == chp_pkg::S_DONE) && out_free;
    assign walk_match = (slot_rdata.key == r_key);
    assign hash_word  = i_key[chp_pkg::KEY_W-1:chp_pkg::HASH_WORD_W]
                        ^ i_key[chp_pkg::HASH_WORD_W-1:0];
    assign fill_sum   = {1'b0, r_hit_ent.fill} + {1'b0, r_len};
    assign cap_pick   = (r_tmax != '0) ? r_tmax : chp_pkg::TMAX_W'(r_default_cap);
    assign clr_next   = r_clr_cnt + 1'b1;
    assign slot_ext   = (SW + chp_pkg::OUT_SLOT_W)'(r_res_slot);

    chp_hash #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc && !req_bad),
        .i_word   (hash_word),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    chp_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH ($bits(t_slot_ent)),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    chp_ram #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH ($bits(t_bkt_ent)),
        .AW    (BW)
    ) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chp_pkg::S_CLEAR: begin
                if (r_clr_cnt == CW'(CLR_DEPTH - 1)) begin
                    n_state = chp_pkg::S_IDLE;
                end
            end
            chp_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = req_bad ? chp_pkg::S_DONE : chp_pkg::S_HASH;
                end
            end
            chp_pkg::S_HASH: begin
                if (hash_done) begin
                    n_state = chp_pkg::S_BKT_WAIT;
                end
            end
            chp_pkg::S_BKT_WAIT: begin
                n_state = bkt_rdata.hv ? chp_pkg::S_WALK : chp_pkg::S_RESOLVE;
            end
            chp_pkg::S_WALK: begin
                if (walk_match || !slot_rdata.nv) begin
                    n_state = chp_pkg::S_RESOLVE;
                end
            end
            chp_pkg::S_RESOLVE: begin
                case (r_type)
                    chp_pkg::REQ_APPEND: begin
                        n_state = (!r_hit && r_free_valid) ? chp_pkg::S_ALLOC
                                                           : chp_pkg::S_DONE;
                    end
                    chp_pkg::REQ_RELEASE: begin
                        n_state = r_hit ? chp_pkg::S_UNLINK : chp_pkg::S_DONE;
                    end
                    default: begin
                        n_state = chp_pkg::S_DONE;
                    end
                endcase
            end
            chp_pkg::S_ALLOC: begin
                n_state = chp_pkg::S_DONE;
            end
            chp_pkg::S_UNLINK: begin
                n_state = chp_pkg::S_DONE;
            end
            chp_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = chp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chp_pkg::S_IDLE;
            end
        endcase
    end

    // Memory accesses and register updates per state
    always_comb begin
        n_free_head  = r_free_head;
        n_free_valid = r_free_valid;
        n_bucket     = r_bucket;
        n_bhead      = r_bhead;
        n_bvalid     = r_bvalid;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_has_prev   = r_has_prev;
        n_hit        = r_hit;
        n_prev_ent   = r_prev_ent;
        n_hit_ent    = r_hit_ent;
        n_cap        = r_cap;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_slot   = r_res_slot;
        n_res_off    = r_res_off;
        slot_we      = 1'b0;
        slot_waddr   = r_cur;
        slot_wdata   = r_hit_ent;
        slot_raddr   = r_cur;
        bkt_we       = 1'b0;
        bkt_waddr    = r_bucket;
        bkt_wslot    = r_cur;
        bkt_wdata    = '{head: r_cur, hv: 1'b1};
        bkt_raddr    = r_bucket;
        case (r_state)
            // Initialize slot free chain and empty buckets, one entry a cycle
            chp_pkg::S_CLEAR: begin
                slot_we          = (r_clr_cnt < CW'(NUM_SLOTS));
                slot_waddr       = r_clr_cnt[SW-1:0];
                slot_wdata       = '0;
                slot_wdata.nv    = (clr_next < CW'(NUM_SLOTS));
                slot_wdata.next  = slot_wdata.nv ? clr_next[SW-1:0] : '0;
                bkt_we           = (r_clr_cnt < CW'(NUM_BUCKETS));
                bkt_waddr        = r_clr_cnt[BW-1:0];
                bkt_wdata        = '0;
            end
            chp_pkg::S_IDLE: begin
                n_has_prev   = 1'b0;
                n_hit        = 1'b0;
                n_res_status = req_bad ? chp_pkg::ST_INVALID : chp_pkg::ST_OK;
                n_res_found  = 1'b0;
                n_res_slot   = '0;
                n_res_off    = '0;
            end
            chp_pkg::S_HASH: begin
                bkt_raddr = hash_bucket;
                if (hash_done) begin
                    n_bucket = hash_bucket;
                end
            end
            // Bucket head arrives: start the walk when the bucket is not empty
            chp_pkg::S_BKT_WAIT: begin
                n_bhead    = bkt_rdata.head;
                n_bvalid   = bkt_rdata.hv;
                n_cur      = bkt_rdata.head;
                slot_raddr = bkt_rdata.head;
            end
            // One chain entry per cycle
            chp_pkg::S_WALK: begin
                if (walk_match) begin
                    n_hit     = 1'b1;
                    n_hit_ent = slot_rdata;
                end else if (slot_rdata.nv) begin
                    n_prev_ent = slot_rdata;
                    n_prev     = r_cur;
                    n_has_prev = 1'b1;
                    n_cur      = slot_rdata.next;
                    slot_raddr = slot_rdata.next;
                end
            end
            chp_pkg::S_RESOLVE: begin
                case (r_type)
                    chp_pkg::REQ_APPEND: begin
                        if (r_hit) begin
                            n_res_found = 1'b1;
                            n_res_slot  = r_cur;
                            n_res_off   = r_hit_ent.fill;
                            if (fill_sum > {1'b0, r_hit_ent.cap}) begin
                                n_res_status = chp_pkg::ST_EXCEEDS;
                            end else begin
                                slot_we         = 1'b1;
                                slot_wdata.fill = fill_sum[chp_pkg::LEN_W-1:0];
                            end
                        end else if (!r_free_valid) begin
                            n_res_status = chp_pkg::ST_POOL_FULL;
                        end else begin
                            // fetch the free head's link; clamp the capacity
                            slot_raddr = r_free_head;
                            n_cap = (cap_pick > chp_pkg::TMAX_W'(r_hard_limit))
                                    ? r_hard_limit : cap_pick[chp_pkg::LEN_W-1:0];
                        end
                    end
                    chp_pkg::REQ_QUERY: begin
                        if (r_hit) begin
                            n_res_found = 1'b1;
                            n_res_slot  = r_cur;
                            n_res_off   = r_hit_ent.fill;
                        end
                    end
                    chp_pkg::REQ_RELEASE: begin
                        if (r_hit) begin
                            n_res_found  = 1'b1;
                            n_res_slot   = r_cur;
                            slot_we      = 1'b1;
                            slot_wdata   = '{key: '0, next: r_free_head, nv: r_free_valid,
                                             fill: '0, cap: '0};
                            n_free_head  = r_cur;
                            n_free_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_res_status = chp_pkg::ST_INVALID;
                    end
                endcase
            end
            // New slot at the chain head
            chp_pkg::S_ALLOC: begin
                n_free_head  = slot_rdata.next;
                n_free_valid = slot_rdata.nv;
                n_res_slot   = r_free_head;
                slot_we      = 1'b1;
                slot_waddr   = r_free_head;
                slot_wdata   = '{key: r_key, next: r_bhead, nv: r_bvalid,
                                 fill: r_len, cap: r_cap};
                if (r_len > r_cap) begin
                    n_res_status    = chp_pkg::ST_EXCEEDS;
                    slot_wdata.fill = '0;
                end
                bkt_we    = 1'b1;
                bkt_wslot = r_free_head;
                bkt_wdata = '{head: bkt_wslot, hv: 1'b1};
            end
            // Bypass the released slot
            chp_pkg::S_UNLINK: begin
                if (r_has_prev) begin
                    slot_we         = 1'b1;
                    slot_waddr      = r_prev;
                    slot_wdata      = r_prev_ent;
                    slot_wdata.next = r_hit_ent.next;
                    slot_wdata.nv   = r_hit_ent.nv;
                end else begin
                    bkt_we    = 1'b1;
                    bkt_wdata = '{head: r_hit_ent.next, hv: r_hit_ent.nv};
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= chp_pkg::S_CLEAR;
            r_clr_cnt     <= '0;
            r_free_head   <= '0;
            r_free_valid  <= 1'b1;
            r_out_valid   <= 1'b0;
            r_default_cap <= chp_pkg::DEFAULT_CAP_RST;
            r_hard_limit  <= chp_pkg::HARD_LIMIT_RST;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_free_valid <= n_free_valid;
            if (r_state == chp_pkg::S_CLEAR) begin
                r_clr_cnt <= clr_next;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    chp_pkg::CFG_DEFAULT_CAP: r_default_cap <= i_cfg_wdata;
                    chp_pkg::CFG_HARD_LIMIT:  r_hard_limit  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type <= chp_pkg::t_req'(i_req_type);
            r_key  <= i_key;
            r_len  <= i_append_length;
            r_tmax <= i_type_max_size;
        end
        r_bucket     <= n_bucket;
        r_bhead      <= n_bhead;
        r_bvalid     <= n_bvalid;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_has_prev   <= n_has_prev;
        r_hit        <= n_hit;
        r_prev_ent   <= n_prev_ent;
        r_hit_ent    <= n_hit_ent;
        r_cap        <= n_cap;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_slot   <= n_res_slot;
        r_res_off    <= n_res_off;
        if (load_out) begin
            r_o_status <= r_res_status;
            r_o_found  <= r_res_found;
            r_o_slot   <= slot_ext[chp_pkg::OUT_SLOT_W-1:0];
            r_o_off    <= r_res_off;
        end
    end

    assign o_in_stall    = (r_state != chp_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_slot_index  = r_o_slot;
    assign o_byte_offset = r_o_off;

`ifndef SYNTHESIS
    // An accepted request goes to hashing, or straight to the result when invalid
    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=>
            (r_state == chp_pkg::S_HASH || r_state == chp_pkg::S_DONE))
        else $error("accepted request took an unexpected path");

    // Allocation only happens with a non-empty free list
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chp_pkg::S_ALLOC) |->
            ($past(r_state) == chp_pkg::S_RESOLVE && $past(r_free_valid)))
        else $error("allocation from an empty free list");

    // Unlinking only follows a release that hit
    a_unlink_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chp_pkg::S_UNLINK) |-> (r_hit && r_type == chp_pkg::REQ_RELEASE))
        else $error("unlink without a release hit");

    // A waiting result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chp_pkg::S_DONE && r_out_valid && i_out_stall) |=>
            ($stable(o_byte_offset) && $stable(o_slot_index) && r_state == chp_pkg::S_DONE))
        else $error("pending result overwritten");
`endif

endmodule
